// File: src/anc_pkg.sv
// Shared types, constants and helpers for the ARP neighbor cache.
package anc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_BITS      = 10;
    localparam int ADDR_W        = 32;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int SEC_W         = 16;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;

    // Input tdata layout, lowest bit first
    localparam int IN_A_LO       = 0;
    localparam int IN_B_LO       = IN_A_LO + ADDR_W;
    localparam int IN_MAC_LO     = IN_B_LO + ADDR_W;
    localparam int IN_NOW_LO     = IN_MAC_LO + MAC_W;
    localparam int IN_TAG_LO     = IN_NOW_LO + TIME_W;
    localparam int IN_DATA_BITS  = IN_TAG_LO + TAG_BITS;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W    = 3;

    // Output tdata layout, lowest bit first
    localparam int OUT_MAC_LO    = 0;
    localparam int OUT_ADDR_LO   = OUT_MAC_LO + MAC_W;
    localparam int OUT_TAG_LO    = OUT_ADDR_LO + ADDR_W;
    localparam int OUT_DATA_BITS = OUT_TAG_LO + TAG_BITS;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 3;

    localparam logic [ADDR_W-1:0] ADDR_BCAST    = '1;
    localparam logic [MAC_W-1:0]  MAC_BCAST     = '1;
    localparam logic [23:0]       MCAST_PREFIX  = 24'h01005E;
    localparam logic [3:0]        MCAST_NET     = 4'hE;

    localparam logic [SEC_W-1:0]  LIFETIME_RST  = 16'd180;
    localparam logic [SEC_W-1:0]  HOLD_RST      = 16'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        KIND_TX        = 3'd0,
        KIND_ARP_REQ   = 3'd1,
        KIND_ARP_REPLY = 3'd2,
        KIND_RELEASE   = 3'd3,
        KIND_BAD_ARP   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_REPLY   = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_ILLEGAL = 2'd3
    } t_action;

    // EMIT: result fully formed by the front; SEND/REPLY: needs the table
    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_SEND  = 2'd1,
        OP_REPLY = 2'd2
    } t_op;

    typedef struct packed {
        logic [ADDR_W-1:0] local_ip;
        logic [ADDR_W-1:0] subnet_mask;
        logic [ADDR_W-1:0] gateway_ip;
        logic [SEC_W-1:0]  entry_lifetime;
        logic [SEC_W-1:0]  hold_limit;
    } t_cfg;

    typedef struct packed {
        t_kind               kind;
        logic [MAC_W-1:0]    mac;
        logic [ADDR_W-1:0]   addr;
        logic [TAG_BITS-1:0] tag;
    } t_result;

    typedef struct packed {
        t_op               op;
        t_result           res;
        logic [TIME_W-1:0] now;
    } t_qitem;

    typedef struct packed {
        logic                empty;
        logic                full;
    } t_qstat;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   stamp;
        logic [TIME_W-1:0]   refresh_stamp;
        logic                complete;
        logic [MAC_W-1:0]    mac;
        logic                holding;
        logic [TAG_BITS-1:0] held_tag;
    } t_entry;

    function automatic logic is_mcast(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:ADDR_W-4] == MCAST_NET;
    endfunction

endpackage

// File: src/anc_front.sv
// Front end: accepts input items, picks the next hop and classifies them.
module anc_front (
    input  anc_pkg::t_cfg                     i_cfg,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [anc_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic [anc_pkg::IN_TUSER_W-1:0]    i_tuser,
    input  anc_pkg::t_qstat                   i_qstat,
    output logic                              o_push,
    output anc_pkg::t_qitem                   o_item
);

    anc_pkg::t_action                 act;
    logic                             fmt_ok;
    logic [anc_pkg::ADDR_W-1:0]       addr_a;
    logic [anc_pkg::ADDR_W-1:0]       addr_b;
    logic [anc_pkg::MAC_W-1:0]        smac;
    logic [anc_pkg::TIME_W-1:0]       now;
    logic [anc_pkg::TAG_BITS-1:0]     tag;
    logic [anc_pkg::ADDR_W-1:0]       hop;
    logic                             keep;

    assign act    = anc_pkg::t_action'(i_tuser[1:0]);
    assign fmt_ok = i_tuser[2];
    assign addr_a = i_tdata[anc_pkg::IN_A_LO +: anc_pkg::ADDR_W];
    assign addr_b = i_tdata[anc_pkg::IN_B_LO +: anc_pkg::ADDR_W];
    assign smac   = i_tdata[anc_pkg::IN_MAC_LO +: anc_pkg::MAC_W];
    assign now    = i_tdata[anc_pkg::IN_NOW_LO +: anc_pkg::TIME_W];
    assign tag    = i_tdata[anc_pkg::IN_TAG_LO +: anc_pkg::TAG_BITS];

    always_comb begin
        if (addr_a == '0 || addr_a == anc_pkg::ADDR_BCAST) begin
            hop = anc_pkg::ADDR_BCAST;
        end else if (anc_pkg::is_mcast(addr_a)) begin
            hop = addr_a;
        end else if ((i_cfg.local_ip & i_cfg.subnet_mask) != (addr_a & i_cfg.subnet_mask)) begin
            hop = i_cfg.gateway_ip;
        end else begin
            hop = addr_a;
        end
    end

    always_comb begin
        keep            = 1'b1;
        o_item.op       = anc_pkg::OP_EMIT;
        o_item.now      = now;
        o_item.res.kind = anc_pkg::KIND_BAD_ARP;
        o_item.res.mac  = '0;
        o_item.res.addr = '0;
        o_item.res.tag  = '0;
        case (act)
            anc_pkg::ACT_SEND: begin
                o_item.res.kind = anc_pkg::KIND_TX;
                o_item.res.addr = hop;
                o_item.res.tag  = tag;
                if (hop == anc_pkg::ADDR_BCAST) begin
                    o_item.res.mac = anc_pkg::MAC_BCAST;
                end else if (anc_pkg::is_mcast(hop)) begin
                    o_item.res.mac = {anc_pkg::MCAST_PREFIX, 1'b0, hop[22:0]};
                end else begin
                    o_item.op = anc_pkg::OP_SEND;
                end
            end
            anc_pkg::ACT_REPLY: begin
                // bad unless well formed, aimed at us and from a unicast sender
                if (fmt_ok && addr_b == i_cfg.local_ip && !smac[40]) begin
                    o_item.op       = anc_pkg::OP_REPLY;
                    o_item.res.kind = anc_pkg::KIND_TX;
                    o_item.res.mac  = smac;
                    o_item.res.addr = addr_a;
                end
            end
            anc_pkg::ACT_REQUEST: begin
                if (fmt_ok) begin
                    keep            = (addr_b == i_cfg.local_ip);
                    o_item.res.kind = anc_pkg::KIND_ARP_REPLY;
                    o_item.res.mac  = smac;
                    o_item.res.addr = addr_a;
                end
            end
            default: begin
                keep = 1'b1;
            end
        endcase
    end

    // Drop requests for other hosts: accepted, nothing queued
    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full && keep;

endmodule

// File: src/anc_queue.sv
// Short queue of classified items between the front end and the table engine.
module anc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  anc_pkg::t_qitem  i_item,
    input  logic             i_pop,
    output anc_pkg::t_qitem  o_item,
    output anc_pkg::t_qstat  o_qstat
);

    anc_pkg::t_qitem                r_slot [anc_pkg::QUEUE_DEPTH];
    logic [anc_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [anc_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [anc_pkg::QCNT_W-1:0]     r_count;
    logic [anc_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [anc_pkg::QPTR_W-1:0]     n_rd_ptr;

    localparam logic [anc_pkg::QPTR_W-1:0] LAST_PTR = anc_pkg::QPTR_W'(anc_pkg::QUEUE_DEPTH - 1);
    localparam logic [anc_pkg::QCNT_W-1:0] FULL_CNT = anc_pkg::QCNT_W'(anc_pkg::QUEUE_DEPTH);

    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == FULL_CNT);
    assign o_item        = r_slot[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/anc_back.sv
// Table engine: reads one cache entry, updates it and emits up to two results.
module anc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  anc_pkg::t_cfg    i_cfg,
    input  anc_pkg::t_qstat  i_qstat,
    input  anc_pkg::t_qitem  i_item,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output anc_pkg::t_result o_result,
    output logic             o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    anc_pkg::t_qitem                r_cur;
    anc_pkg::t_entry                r_mem [anc_pkg::TABLE_ENTRIES];
    logic [anc_pkg::TABLE_ENTRIES-1:0] r_valid;
    anc_pkg::t_entry                r_rd_entry;
    logic                           r_rd_valid;
    anc_pkg::t_result               r_out;
    anc_pkg::t_result               r_next;
    logic                           r_has_next;

    anc_pkg::t_entry                ent;
    anc_pkg::t_entry                wr_entry;
    logic                           wr_en;
    logic [anc_pkg::TIME_W-1:0]     age;
    logic                           hit;
    logic                           refresh;
    logic                           stale;
    anc_pkg::t_result               res0;
    anc_pkg::t_result               res1;
    logic [1:0]                     res_cnt;
    logic                           out_done;
    logic [anc_pkg::IDX_W-1:0]      rd_idx;
    logic [anc_pkg::IDX_W-1:0]      wr_idx;

    assign out_done = (r_state == S_EMIT) && i_tready && !r_has_next;
    assign o_pop    = ((r_state == S_IDLE) || out_done) && !i_qstat.empty;
    assign rd_idx   = i_item.res.addr[anc_pkg::IDX_W-1:0];
    assign wr_idx   = r_cur.res.addr[anc_pkg::IDX_W-1:0];

    // Never-written entries read as all zero
    assign ent   = r_rd_valid ? r_rd_entry : '0;
    assign age   = r_cur.now - ent.stamp;
    assign hit   = (ent.addr == r_cur.res.addr) && ent.complete
                   && (age < {16'd0, i_cfg.entry_lifetime});
    assign refresh = (age > {17'd0, i_cfg.entry_lifetime[anc_pkg::SEC_W-1:1]})
                     && (ent.refresh_stamp != r_cur.now);
    assign stale = ent.holding && (age > {16'd0, i_cfg.hold_limit});

    always_comb begin
        wr_en    = 1'b0;
        wr_entry = ent;
        res0     = '0;
        res1     = '0;
        res_cnt  = 2'd0;
        case (r_cur.op)
            anc_pkg::OP_SEND: begin
                if (hit) begin
                    res1.kind = anc_pkg::KIND_TX;
                    res1.mac  = ent.mac;
                    res1.addr = r_cur.res.addr;
                    res1.tag  = r_cur.res.tag;
                    if (refresh) begin
                        wr_en                  = 1'b1;
                        wr_entry.refresh_stamp = r_cur.now;
                        res0.kind              = anc_pkg::KIND_ARP_REQ;
                        res0.mac               = anc_pkg::MAC_BCAST;
                        res0.addr              = r_cur.res.addr;
                        res_cnt                = 2'd2;
                    end else begin
                        res0    = res1;
                        res_cnt = 2'd1;
                    end
                end else begin
                    // install incomplete entry and hold the new tag
                    wr_en             = 1'b1;
                    wr_entry.addr     = r_cur.res.addr;
                    wr_entry.mac      = '0;
                    wr_entry.holding  = 1'b1;
                    wr_entry.held_tag = r_cur.res.tag;
                    wr_entry.stamp    = r_cur.now;
                    wr_entry.complete = 1'b0;
                    res1.kind         = anc_pkg::KIND_ARP_REQ;
                    res1.mac          = anc_pkg::MAC_BCAST;
                    res1.addr         = r_cur.res.addr;
                    if (ent.holding) begin
                        res0.kind = anc_pkg::KIND_RELEASE;
                        res0.tag  = ent.held_tag;
                        res_cnt   = 2'd2;
                    end else begin
                        res0    = res1;
                        res_cnt = 2'd1;
                    end
                end
            end
            anc_pkg::OP_REPLY: begin
                if (ent.addr != r_cur.res.addr) begin
                    res0.kind = anc_pkg::KIND_BAD_ARP;
                    res_cnt   = 2'd1;
                end else begin
                    wr_en             = 1'b1;
                    wr_entry.mac      = r_cur.res.mac;
                    wr_entry.stamp    = r_cur.now;
                    wr_entry.complete = 1'b1;
                    wr_entry.holding  = 1'b0;
                    if (stale) begin
                        res0.kind = anc_pkg::KIND_RELEASE;
                        res0.tag  = ent.held_tag;
                        res_cnt   = 2'd1;
                    end else if (ent.holding) begin
                        res0.kind = anc_pkg::KIND_TX;
                        res0.mac  = r_cur.res.mac;
                        res0.addr = r_cur.res.addr;
                        res0.tag  = ent.held_tag;
                        res_cnt   = 2'd1;
                    end
                end
            end
            default: begin
                res_cnt = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_EMIT: begin
                if (o_pop) begin
                    n_state = (i_item.op == anc_pkg::OP_EMIT) ? S_EMIT : S_LOOK;
                end else if (out_done) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                n_state = (res_cnt == 2'd0) ? S_IDLE : S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: read on pop, written back in the lookup cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_entry <= r_mem[rd_idx];
        end
        if ((r_state == S_LOOK) && wr_en) begin
            r_mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
        end
        if (o_pop && (i_item.op == anc_pkg::OP_EMIT)) begin
            r_out <= i_item.res;
        end else if (r_state == S_LOOK) begin
            r_out  <= res0;
            r_next <= res1;
        end else if ((r_state == S_EMIT) && i_tready && r_has_next) begin
            r_out <= r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_has_next <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_rd_valid <= r_valid[rd_idx];
            end
            if ((r_state == S_LOOK) && wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (o_pop) begin
                r_has_next <= 1'b0;
            end else if (r_state == S_LOOK) begin
                r_has_next <= (res_cnt == 2'd2);
            end else if ((r_state == S_EMIT) && i_tready) begin
                r_has_next <= 1'b0;
            end
        end
    end

    assign o_tvalid = (r_state == S_EMIT);
    assign o_result = r_out;
    assign o_last   = !r_has_next;

endmodule

// File: src/arp_neighbor_cache_core.sv
// ARP neighbor cache: top level with configuration registers.
//
// Input items arrive on the s_axis channel: tuser carries the action and the
// ARP format flag, tdata the addresses, sender MAC, time and packet tag.
// Each item gives zero, one or two result items on m_axis; tlast marks the
// final result of an item. Configuration writes use the cfg channel, which is
// always ready, and must only be issued while the block is idle.
// The front end classifies an item in the cycle it is accepted and places it
// in a two-entry queue. The table engine reads the entry of an item that needs
// the 64-entry table, then updates it and writes it back; results then go out
// one per cycle while m_axis is ready. Items resolved by the front end alone
// skip the table. The engine takes the next queued item when the last result
// of the current one is accepted.
// When m_axis stalls, the current result holds and the queue keeps taking
// items until it is full. Reset empties the queue, marks every table entry as
// never written (reads as zero) and restores lifetime 180 and hold limit 5.
module arp_neighbor_cache_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // addr_a, addr_b, sender_mac, now_seconds, packet_tag, zero pad
    input  logic [anc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // action, format_ok
    input  logic [anc_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // dest_mac, target_addr, tag_out, zero pad
    output logic [anc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // kind
    output logic [anc_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [anc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [anc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    anc_pkg::t_cfg     r_cfg;
    anc_pkg::t_qstat   qstat;
    anc_pkg::t_qitem   push_item;
    anc_pkg::t_qitem   head_item;
    anc_pkg::t_result  result;
    logic              push;
    logic              pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_ip       <= '0;
            r_cfg.subnet_mask    <= '0;
            r_cfg.gateway_ip     <= '0;
            r_cfg.entry_lifetime <= anc_pkg::LIFETIME_RST;
            r_cfg.hold_limit     <= anc_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                anc_pkg::CFG_LOCAL_IP:   r_cfg.local_ip       <= i_cfg_data[anc_pkg::ADDR_W-1:0];
                anc_pkg::CFG_SUBNET:     r_cfg.subnet_mask    <= i_cfg_data[anc_pkg::ADDR_W-1:0];
                anc_pkg::CFG_GATEWAY:    r_cfg.gateway_ip     <= i_cfg_data[anc_pkg::ADDR_W-1:0];
                anc_pkg::CFG_LIFETIME:   r_cfg.entry_lifetime <= i_cfg_data[anc_pkg::SEC_W-1:0];
                anc_pkg::CFG_HOLD_LIMIT: r_cfg.hold_limit     <= i_cfg_data[anc_pkg::SEC_W-1:0];
                // station MAC feeds no result; accept and drop the write
                anc_pkg::CFG_LOCAL_MAC: begin
                end
                default: begin
                end
            endcase
        end
    end

    anc_front u_front (
        .i_cfg    (r_cfg),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_item   (push_item)
    );

    anc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    anc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (qstat),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_result (result),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(anc_pkg::OUT_TDATA_W - anc_pkg::OUT_DATA_BITS){1'b0}},
                             result.tag, result.addr, result.mac};
    assign o_m_axis_tuser = result.kind;

endmodule

// File: src/anc_checker.sv
// Port-level checks for the ARP neighbor cache, bound to the top level.
module anc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [anc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [anc_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);

    localparam int MAC_HI = anc_pkg::OUT_MAC_LO + anc_pkg::MAC_W - 1;
    localparam int ADR_HI = anc_pkg::OUT_ADDR_LO + anc_pkg::ADDR_W - 1;
    localparam int TAG_HI = anc_pkg::OUT_TAG_LO + anc_pkg::TAG_BITS - 1;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not empty after reset");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == anc_pkg::KIND_RELEASE
                            || o_m_axis_tuser == anc_pkg::KIND_BAD_ARP) |->
            o_m_axis_tdata[ADR_HI:anc_pkg::OUT_MAC_LO] == '0)
        else $error("release or bad ARP carries address data");

    a_request_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == anc_pkg::KIND_ARP_REQ) |->
            o_m_axis_tdata[MAC_HI:anc_pkg::OUT_MAC_LO] == anc_pkg::MAC_BCAST
            && o_m_axis_tdata[TAG_HI:anc_pkg::OUT_TAG_LO] == '0)
        else $error("ARP request not broadcast or carries a tag");

    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == anc_pkg::KIND_BAD_ARP) |-> o_m_axis_tlast)
        else $error("bad ARP result not final");

endmodule

bind arp_neighbor_cache_core anc_checker u_anc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: tb/tb_arp_neighbor_cache_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ARP neighbor cache core: directed table, then random traffic.
module tb_arp_neighbor_cache_core;
    import anc_pkg::*;

    localparam int RANDOM_PER_SETTING = 250;
    localparam int SETTLE_CYCLES      = 12;
    localparam int POOL_SIZE          = 8;
    localparam int GROUP_BIT          = 40;

    typedef struct packed {
        t_action             act;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   b;
        logic [MAC_W-1:0]    smac;
        logic                fmt;
        logic [TIME_W-1:0]   now;
        logic [TAG_BITS-1:0] tag;
    } arp_item_t;

    typedef struct packed {
        t_kind               kind;
        logic [MAC_W-1:0]    mac;
        logic [ADDR_W-1:0]   addr;
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } arp_result_t;

    // typed rows carry their own result count and (single) result
    typedef struct packed {
        arp_item_t           item;
        logic                typed;
        logic [1:0]          n;
        t_kind               kind;
        logic [MAC_W-1:0]    mac;
        logic [ADDR_W-1:0]   addr;
        logic [TAG_BITS-1:0] tag;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // broadcast and multicast sends
        '{'{ACT_SEND, 32'h00000000, 32'hFFFFFFFF, 48'h0, 1'b0, 32'd10, 10'h3FF},
          1'b1, 2'd1, KIND_TX, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 10'h3FF},
        '{'{ACT_SEND, 32'hFFFFFFFF, 32'h0, 48'hFFFFFFFFFFFF, 1'b1, 32'd10, 10'h000},
          1'b1, 2'd1, KIND_TX, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 10'h000},
        '{'{ACT_SEND, 32'hE0000001, 32'h0, 48'h0, 1'b1, 32'd11, 10'h005},
          1'b1, 2'd1, KIND_TX, 48'h01005E000001, 32'hE0000001, 10'h005},
        '{'{ACT_SEND, 32'hEFFFFFFF, 32'h0, 48'h0, 1'b1, 32'd11, 10'h2AA},
          1'b1, 2'd1, KIND_TX, 48'h01005E7FFFFF, 32'hEFFFFFFF, 10'h2AA},
        // malformed frames and the unused action
        '{'{ACT_ILLEGAL, 32'h0A000002, 32'h0, 48'h0, 1'b1, 32'd12, 10'h001},
          1'b1, 2'd1, KIND_BAD_ARP, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h00000000, 32'h0, 48'h0, 1'b0, 32'd12, 10'h000},
          1'b1, 2'd1, KIND_BAD_ARP, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REQUEST, 32'h0A000002, 32'h0, 48'h0A1B2C3D4E5F, 1'b0, 32'd12, 10'h000},
          1'b1, 2'd1, KIND_BAD_ARP, 48'h0, 32'h0, 10'h000},
        // requests for us and for someone else
        '{'{ACT_REQUEST, 32'h0A000002, 32'h0, 48'h0A1B2C3D4E5F, 1'b1, 32'd13, 10'h000},
          1'b1, 2'd1, KIND_ARP_REPLY, 48'h0A1B2C3D4E5F, 32'h0A000002, 10'h000},
        '{'{ACT_REQUEST, 32'hFFFFFFFF, 32'h0, 48'hFFFFFFFFFFFF, 1'b1, 32'd13, 10'h000},
          1'b1, 2'd1, KIND_ARP_REPLY, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 10'h000},
        '{'{ACT_REQUEST, 32'h0A000002, 32'h1, 48'h0A1B2C3D4E5F, 1'b1, 32'd13, 10'h000},
          1'b1, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        // miss, repeated miss, resolve, hit, refresh, expiry
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd100, 10'h007},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd101, 10'h008},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h0A000002, 32'h0, 48'h00AABBCCDDEE, 1'b1, 32'd102, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd150, 10'h009},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd200, 10'h00A},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd200, 10'h00B},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_SEND, 32'h0A000002, 32'h0, 48'h0, 1'b0, 32'd282, 10'h00C},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        // rejected replies: group MAC, unknown sender, not for us
        '{'{ACT_REPLY, 32'h0A000002, 32'h0, 48'h010000000000, 1'b1, 32'd283, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h0A000003, 32'h0, 48'h00AABBCCDDEE, 1'b1, 32'd284, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h0A000002, 32'h1, 48'h00AABBCCDDEE, 1'b1, 32'd285, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        // late reply drops the held tag, then a reply with nothing held
        '{'{ACT_REPLY, 32'h0A000002, 32'h0, 48'h00AABBCCDDEF, 1'b1, 32'd290, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h0A000002, 32'h0, 48'h000000000000, 1'b1, 32'd291, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        // time wraps between request and reply
        '{'{ACT_SEND, 32'h0A00003F, 32'hFFFFFFFF, 48'h0, 1'b1, 32'hFFFFFFFF, 10'h3FF},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000},
        '{'{ACT_REPLY, 32'h0A00003F, 32'h0, 48'hFEFFFFFFFFFF, 1'b1, 32'd3, 10'h000},
          1'b0, 2'd0, KIND_TX, 48'h0, 32'h0, 10'h000}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   no_gaps   = 1'b0;

    // predictor copy of the registers
    logic [ADDR_W-1:0]      cf_local_ip  = '0;
    logic [MAC_W-1:0]       cf_local_mac = '0;
    logic [ADDR_W-1:0]      cf_mask      = '0;
    logic [ADDR_W-1:0]      cf_gateway   = '0;
    logic [SEC_W-1:0]       cf_lifetime  = LIFETIME_RST;
    logic [SEC_W-1:0]       cf_hold      = HOLD_RST;

    // predictor copy of the neighbor table
    logic [ADDR_W-1:0]      nc_addr     [TABLE_ENTRIES] = '{default: '0};
    logic [TIME_W-1:0]      nc_stamp    [TABLE_ENTRIES] = '{default: '0};
    logic [TIME_W-1:0]      nc_refresh  [TABLE_ENTRIES] = '{default: '0};
    logic                   nc_complete [TABLE_ENTRIES] = '{default: '0};
    logic [MAC_W-1:0]       nc_mac      [TABLE_ENTRIES] = '{default: '0};
    logic                   nc_holding  [TABLE_ENTRIES] = '{default: '0};
    logic [TAG_BITS-1:0]    nc_held_tag [TABLE_ENTRIES] = '{default: '0};

    arp_result_t            step_out [$];
    arp_result_t            cache_expect [$];
    logic [ADDR_W-1:0]      pool [POOL_SIZE];
    logic [TIME_W-1:0]      clock_s = '0;

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int settings_used = 1;
    int kind_count [5] = '{default: 0};

    arp_neighbor_cache_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 23);
    end

    function automatic void add_result(input t_kind kind, input logic [MAC_W-1:0] mac,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [TAG_BITS-1:0] tag);
        arp_result_t r;
        r.kind = kind;
        r.mac  = mac;
        r.addr = addr;
        r.tag  = tag;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // Work out the result items of one accepted item and update the table copy.
    function automatic void cache_step(input arp_item_t it);
        logic [ADDR_W-1:0] hop;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] age;
        arp_result_t       tail;
        step_out.delete();
        if (it.act == ACT_SEND) begin
            hop = it.a;
            if (hop == '0 || hop == ADDR_BCAST)
                hop = ADDR_BCAST;
            else if (hop[ADDR_W-1 -: 4] != MCAST_NET && (cf_local_ip & cf_mask) != (hop & cf_mask))
                hop = cf_gateway;
            idx = hop[IDX_W-1:0];
            age = it.now - nc_stamp[idx];
            if (hop == ADDR_BCAST) begin
                add_result(KIND_TX, MAC_BCAST, hop, it.tag);
            end else if (hop[ADDR_W-1 -: 4] == MCAST_NET) begin
                add_result(KIND_TX, {MCAST_PREFIX, 1'b0, hop[22:0]}, hop, it.tag);
            end else if (nc_addr[idx] == hop && nc_complete[idx] && age < TIME_W'(cf_lifetime)) begin
                // past half the lifetime: ask again, at most once per second
                if (age > TIME_W'(cf_lifetime >> 1) && nc_refresh[idx] != it.now) begin
                    nc_refresh[idx] = it.now;
                    add_result(KIND_ARP_REQ, MAC_BCAST, hop, '0);
                end
                add_result(KIND_TX, nc_mac[idx], hop, it.tag);
            end else begin
                if (nc_holding[idx])
                    add_result(KIND_RELEASE, '0, '0, nc_held_tag[idx]);
                nc_addr[idx]     = hop;
                nc_mac[idx]      = '0;
                nc_holding[idx]  = 1'b1;
                nc_held_tag[idx] = it.tag;
                nc_stamp[idx]    = it.now;
                nc_complete[idx] = 1'b0;
                add_result(KIND_ARP_REQ, MAC_BCAST, hop, '0);
            end
        end else if (it.act == ACT_ILLEGAL || !it.fmt) begin
            add_result(KIND_BAD_ARP, '0, '0, '0);
        end else if (it.act == ACT_REPLY) begin
            idx = it.a[IDX_W-1:0];
            age = it.now - nc_stamp[idx];
            if (nc_addr[idx] != it.a || it.b != cf_local_ip || it.smac[GROUP_BIT]) begin
                add_result(KIND_BAD_ARP, '0, '0, '0);
            end else begin
                nc_mac[idx] = it.smac;
                // a tag held too long is dropped, not sent
                if (nc_holding[idx] && age > TIME_W'(cf_hold)) begin
                    add_result(KIND_RELEASE, '0, '0, nc_held_tag[idx]);
                    nc_holding[idx] = 1'b0;
                end
                nc_stamp[idx]    = it.now;
                nc_complete[idx] = 1'b1;
                if (nc_holding[idx]) begin
                    nc_holding[idx] = 1'b0;
                    add_result(KIND_TX, it.smac, it.a, nc_held_tag[idx]);
                end
            end
        end else if (it.b == cf_local_ip) begin
            add_result(KIND_ARP_REPLY, it.smac, it.a, '0);
        end
        if (step_out.size() != 0) begin
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    // Addresses for the current setting; several share a table index.
    function automatic void build_pool();
        logic [ADDR_W-1:0] host;
        pool[0] = cf_gateway;
        for (int k = 1; k < POOL_SIZE; k++) begin
            host = $urandom;
            host[IDX_W-1:0] = IDX_W'(k % 5);
            pool[k] = (cf_local_ip & cf_mask) | (host & ~cf_mask);
        end
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t   it;
        int unsigned pick;
        // advance the seconds count, now and then by a lot
        pick = $urandom_range(0, 149);
        if (pick == 0)
            clock_s = $urandom;
        else if (pick < 6)
            clock_s += $urandom_range(0, 2 * cf_lifetime + cf_hold);
        else
            clock_s += $urandom_range(0, 3);
        it.act  = ACT_SEND;
        it.a    = pool[$urandom_range(0, POOL_SIZE - 1)];
        it.b    = cf_local_ip;
        it.smac = {16'($urandom), 32'($urandom)};
        it.smac[GROUP_BIT] = 1'b0;
        it.fmt  = 1'b1;
        it.now  = clock_s;
        it.tag  = TAG_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.b = $urandom;
        end else if (pick < 60) begin
            it.act = ACT_REPLY;
        end else if (pick < 68) begin
            it.act = ACT_REQUEST;
            it.a   = $urandom;
        end else if (pick < 74) begin
            it.a = $urandom;
            it.b = $urandom;
            case ($urandom_range(0, 3))
                0: it.a = '0;
                1: it.a = ADDR_BCAST;
                2: it.a[ADDR_W-1 -: 4] = MCAST_NET;
                default: ;
            endcase
        end else if (pick < 84) begin
            it.act = ACT_REPLY;
            case ($urandom_range(0, 2))
                0: it.fmt = 1'b0;
                1: it.b = $urandom;
                default: it.smac[GROUP_BIT] = 1'b1;
            endcase
        end else begin
            it.act  = t_action'($urandom_range(0, 3));
            it.a    = $urandom;
            it.b    = $urandom;
            it.smac = {16'($urandom), 32'($urandom)};
            it.fmt  = $urandom_range(0, 1);
        end
        return it;
    endfunction

    // Offer one item, wait for the handshake and queue what it should produce.
    task automatic send_item(input arp_item_t it, input bit typed, input int typed_n,
                             input arp_result_t typed_res);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_A_LO   +: ADDR_W]   = it.a;
        word[IN_B_LO   +: ADDR_W]   = it.b;
        word[IN_MAC_LO +: MAC_W]    = it.smac;
        word[IN_NOW_LO +: TIME_W]   = it.now;
        word[IN_TAG_LO +: TAG_BITS] = it.tag;
        while (!no_gaps && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {it.fmt, it.act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        cache_step(it);
        if (typed) begin
            if (typed_n != 0)
                cache_expect.push_back(typed_res);
        end else begin
            foreach (step_out[k]) cache_expect.push_back(step_out[k]);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(random_item(), 1'b0, 0, '0);
    endtask

    // Hold off until every expected result is out and the pipeline is quiet.
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        while (cache_expect.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            CFG_LOCAL_IP:   cf_local_ip  = value[ADDR_W-1:0];
            CFG_LOCAL_MAC:  cf_local_mac = value[MAC_W-1:0];
            CFG_SUBNET:     cf_mask      = value[ADDR_W-1:0];
            CFG_GATEWAY:    cf_gateway   = value[ADDR_W-1:0];
            CFG_LIFETIME:   cf_lifetime  = value[SEC_W-1:0];
            CFG_HOLD_LIMIT: cf_hold      = value[SEC_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [ADDR_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                 input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
                                 input logic [SEC_W-1:0] life, input logic [SEC_W-1:0] hold);
        cfg_write(CFG_LOCAL_IP, CFG_DATA_W'(ip));
        cfg_write(CFG_LOCAL_MAC, CFG_DATA_W'(mac));
        cfg_write(CFG_SUBNET, CFG_DATA_W'(mask));
        cfg_write(CFG_GATEWAY, CFG_DATA_W'(gw));
        cfg_write(CFG_LIFETIME, CFG_DATA_W'(life));
        cfg_write(CFG_HOLD_LIMIT, CFG_DATA_W'(hold));
        cfg_valid <= 1'b0;
        settings_used++;
        build_pool();
    endtask

    always @(posedge clk) begin : result_check
        arp_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser < 5)
                kind_count[m_tuser]++;
            if (cache_expect.size() == 0) begin
                errors++;
                $error("result item with nothing expected: kind %0d", m_tuser);
            end else begin
                want = cache_expect.pop_front();
                if (m_tuser != want.kind) begin
                    errors++;
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                end
                if (m_tdata[OUT_MAC_LO +: MAC_W] != want.mac) begin
                    errors++;
                    $error("dest_mac: expected %h, got %h", want.mac,
                           m_tdata[OUT_MAC_LO +: MAC_W]);
                end
                if (m_tdata[OUT_ADDR_LO +: ADDR_W] != want.addr) begin
                    errors++;
                    $error("target_addr: expected %h, got %h", want.addr,
                           m_tdata[OUT_ADDR_LO +: ADDR_W]);
                end
                if (m_tdata[OUT_TAG_LO +: TAG_BITS] != want.tag) begin
                    errors++;
                    $error("tag_out: expected %h, got %h", want.tag,
                           m_tdata[OUT_TAG_LO +: TAG_BITS]);
                end
                if (m_tlast != want.last) begin
                    errors++;
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        arp_result_t typed_res;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        build_pool();
        foreach (DIRECTED[r]) begin
            typed_res.kind = DIRECTED[r].kind;
            typed_res.mac  = DIRECTED[r].mac;
            typed_res.addr = DIRECTED[r].addr;
            typed_res.tag  = DIRECTED[r].tag;
            typed_res.last = 1'b1;
            send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].n, typed_res);
        end
        run_random(RANDOM_PER_SETTING);
        drain(SETTLE_CYCLES);

        apply_setting(32'h0A000005, 48'h02AABBCCDDEE, 32'hFFFFFF00, 32'h0A000001,
                      16'd20, 16'd3);
        run_random(RANDOM_PER_SETTING);
        drain(SETTLE_CYCLES);

        // shortest lifetime, zero hold, and no idling on either side
        apply_setting(32'hC0A80164, 48'hFFFFFFFFFFFF, 32'hFFFF0000, 32'hC0A80001,
                      16'd1, 16'd0);
        no_gaps <= 1'b1;
        run_random(RANDOM_PER_SETTING);
        drain(SETTLE_CYCLES);
        no_gaps <= 1'b0;

        apply_setting(32'hFFFFFFFF, 48'h000000000000, 32'hFFFFFFFF, 32'h00000000,
                      16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_SETTING);
        drain(SETTLE_CYCLES);

        apply_setting($urandom, {16'($urandom), 32'($urandom)}, 32'h00000000, $urandom,
                      16'd8, 16'd2);
        run_random(RANDOM_PER_SETTING);
        drain(SETTLE_CYCLES);

        apply_setting($urandom, {16'($urandom), 32'($urandom)},
                      32'hFFFFFFFF << $urandom_range(2, 12), $urandom,
                      SEC_W'($urandom_range(2, 40)), SEC_W'($urandom_range(0, 10)));
        run_random(RANDOM_PER_SETTING);
        drain(2 * SETTLE_CYCLES);

        $display("Covered %0d input items under %0d register settings, %0d result items checked",
                 items_sent, settings_used, results_seen);
        $display("Results: %0d transmit, %0d ARP request, %0d ARP reply, %0d release, %0d bad ARP",
                 kind_count[KIND_TX], kind_count[KIND_ARP_REQ], kind_count[KIND_ARP_REPLY],
                 kind_count[KIND_RELEASE], kind_count[KIND_BAD_ARP]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: arp_neighbor_cache_core.f
src/anc_pkg.sv
src/anc_front.sv
src/anc_queue.sv
src/anc_back.sv
src/arp_neighbor_cache_core.sv
src/anc_checker.sv
tb/tb_arp_neighbor_cache_core.sv
